/* src/pf_pkg.sv */
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, codes and small helper functions for the 5x5 Playfair block.
// ----------------------------------------------------------------------------
package pf_pkg;

  // Command codes carried on the input kind field
  localparam logic [1:0] CMD_KEY = 2'd0;
  localparam logic [1:0] CMD_MSG = 2'd1;
  localparam logic [1:0] CMD_END = 2'd2;

  // Register address of the mode register
  localparam logic [1:0] REG_MODE_ADDR = 2'd0;

  // Letter indexes (A = 0) and square geometry
  localparam logic [4:0] LETTER_I    = 5'd8;
  localparam logic [4:0] LETTER_J    = 5'd9;
  localparam logic [4:0] LETTER_X    = 5'd23;
  localparam logic [4:0] LETTER_LAST = 5'd25;
  localparam logic [4:0] NO_LETTER   = 5'd26;
  localparam logic [4:0] CELLS       = 5'd25;
  localparam int         NUM_LETTERS = 26;
  localparam int         NUM_CELLS   = 25;

  localparam logic [7:0] ASCII_UA = 8'h41;
  localparam logic [7:0] ASCII_UZ = 8'h5A;
  localparam logic [7:0] ASCII_UJ = 8'h4A;
  localparam logic [7:0] ASCII_LA = 8'h61;
  localparam logic [7:0] ASCII_LZ = 8'h7A;
  localparam logic [6:0] ASCII_A7 = 7'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_PROC,
    ST_LK_POS,
    ST_LK_SQR,
    ST_LK_OUT
  } pf_state_t;

  // Map a byte to a letter index, case folded and J folded into I;
  // NO_LETTER for anything that is not a letter.
  function automatic logic [4:0] letter_of(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] idx;
    begin
      d   = 8'd0;
      idx = NO_LETTER;
      if (c >= ASCII_UA && c <= ASCII_UZ) begin
        d   = c - ASCII_UA;
        idx = d[4:0];
      end else if (c >= ASCII_LA && c <= ASCII_LZ) begin
        d   = c - ASCII_LA;
        idx = d[4:0];
      end
      if (idx == LETTER_J) begin
        idx = LETTER_I;
      end
      return idx;
    end
  endfunction

  // Row of a cell 0..24
  function automatic logic [2:0] row_of(input logic [4:0] p);
    begin
      if (p >= 5'd20)      return 3'd4;
      else if (p >= 5'd15) return 3'd3;
      else if (p >= 5'd10) return 3'd2;
      else if (p >= 5'd5)  return 3'd1;
      else                 return 3'd0;
    end
  endfunction

  // Column of a cell 0..24
  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [4:0] base;
    logic [4:0] diff;
    begin
      base = {row_of(p), 2'b00} + {2'b00, row_of(p)};
      diff = p - base;
      return diff[2:0];
    end
  endfunction

  // (v + s) mod 5 for v in 0..4 and s in 1..4
  function automatic logic [2:0] add_mod5(input logic [2:0] v, input logic [2:0] s);
    logic [3:0] sum;
    begin
      sum = {1'b0, v} + {1'b0, s};
      if (sum >= 4'd5) begin
        sum = sum - 4'd5;
      end
      return sum[2:0];
    end
  endfunction

  // Cell number from row and column
  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    begin
      return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    end
  endfunction

endpackage

/* src/pf_ram.sv */
// ----------------------------------------------------------------------------
// pf_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pf_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered reads, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

/* src/playfair_cipher.sv */
// A key byte is absorbed in its accept cycle; a pair-completing message byte passes PROC,
// LK_POS, LK_SQR and LK_OUT before its first letter shows, the second as soon as the first
// is taken. Key bytes go one per cycle while idle; a message byte holds the input until
// handled (two dependent reads to close a pair); the first one of a run adds an alphabet
// walk. An untaken result stalls the next pair. Reset clears control state, the used set
// and the mode register; the square memories are not cleared and are rewritten before use.
// ----------------------------------------------------------------------------
// playfair_cipher
// Streaming 5x5 Playfair cipher: builds the square from key bytes, then
// enciphers or deciphers message letters pair by pair.
// ----------------------------------------------------------------------------
module playfair_cipher
  import pf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] char_code
  input  logic [1:0]  in_tuser,     // [1:0] cmd
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [6:0] letter, [7] zero
  output logic        out_tlast,    // pair_last
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pf_state_t state_r, state_nxt;

  logic        mode_r;
  logic [25:0] used_r;
  logic [4:0]  fill_r;
  logic        complete_r;
  logic [4:0]  pend_r;
  logic        pend_v_r;
  logic [4:0]  k_r;
  logic [7:0]  char_r;
  logic [4:0]  pair_a_r, pair_b_r;
  logic [4:0]  out_a_r, out_b_r;
  logic [1:0]  cnt_r;

  logic        in_acc;
  logic        out_acc;
  logic        cfg_wr;
  logic        key_acc;
  logic        end_pair;
  logic [4:0]  cand;
  logic        app_en;
  logic        proc_ok;
  logic [4:0]  proc_idx;
  logic [7:0]  dec_diff;

  logic        pos_re, sq_re;
  logic [4:0]  pos_rd_a, pos_rd_b;
  logic [4:0]  sq_rd_a, sq_rd_b;
  logic [4:0]  oa, ob;
  logic [2:0]  ra, ca, rb, cb, shift;

  // Handshakes
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {31'd0, mode_r};

  assign key_acc  = in_acc && (in_tuser == CMD_KEY) && !complete_r;
  assign end_pair = pend_v_r && !mode_r && complete_r;

  // Append candidate: key letter in idle, alphabet walk in fill
  always_comb begin
    cand   = (state_r == ST_FILL) ? k_r : letter_of(in_tdata);
    app_en = ((state_r == ST_FILL) || (state_r == ST_IDLE && key_acc)) &&
             (cand < NO_LETTER) && (cand != LETTER_J) && (fill_r < CELLS) &&
             !used_r[cand];
  end

  // Classify the held message byte
  always_comb begin
    dec_diff = char_r - ASCII_UA;
    if (mode_r) begin
      proc_ok  = (char_r >= ASCII_UA) && (char_r <= ASCII_UZ) && (char_r != ASCII_UJ);
      proc_idx = dec_diff[4:0];
    end else begin
      proc_idx = letter_of(char_r);
      proc_ok  = (proc_idx != NO_LETTER);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            CMD_MSG: state_nxt = complete_r ? ST_PROC : ST_FILL;
            CMD_END: state_nxt = end_pair ? ST_LK_POS : ST_IDLE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (k_r == LETTER_LAST) state_nxt = ST_PROC;
      end
      ST_PROC: begin
        state_nxt = (proc_ok && pend_v_r) ? ST_LK_POS : ST_IDLE;
      end
      ST_LK_POS: state_nxt = ST_LK_SQR;
      ST_LK_SQR: state_nxt = ST_LK_OUT;
      ST_LK_OUT: begin
        if (cnt_r == 2'd0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    pos_re    = 1'b0;
    sq_re     = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_LK_POS: pos_re    = 1'b1;
      ST_LK_SQR: sq_re     = 1'b1;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Apply the Playfair rule to the two positions
  always_comb begin
    shift = mode_r ? 3'd4 : 3'd1;
    ra = row_of(pos_rd_a);
    ca = col_of(pos_rd_a);
    rb = row_of(pos_rd_b);
    cb = col_of(pos_rd_b);
    if (ra == rb) begin
      oa = cell_of(ra, add_mod5(ca, shift));
      ob = cell_of(rb, add_mod5(cb, shift));
    end else if (ca == cb) begin
      oa = cell_of(add_mod5(ra, shift), ca);
      ob = cell_of(add_mod5(rb, shift), cb);
    end else begin
      oa = cell_of(ra, cb);
      ob = cell_of(rb, ca);
    end
  end

  // Square: cell -> letter
  pf_ram #(.WIDTH(5), .DEPTH(NUM_CELLS)) u_square (
    .clk     (clk),
    .we      (app_en),
    .waddr   (fill_r),
    .wdata   (cand),
    .re      (sq_re),
    .raddr_a (oa),
    .raddr_b (ob),
    .rdata_a (sq_rd_a),
    .rdata_b (sq_rd_b)
  );

  // Position table: letter -> cell
  pf_ram #(.WIDTH(5), .DEPTH(NUM_LETTERS)) u_position (
    .clk     (clk),
    .we      (app_en),
    .waddr   (cand),
    .wdata   (fill_r),
    .re      (pos_re),
    .raddr_a (pair_a_r),
    .raddr_b (pair_b_r),
    .rdata_a (pos_rd_a),
    .rdata_b (pos_rd_b)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= 1'b0;
      used_r     <= '0;
      fill_r     <= '0;
      complete_r <= 1'b0;
      pend_r     <= '0;
      pend_v_r   <= 1'b0;
      k_r        <= '0;
      cnt_r      <= '0;
    end else begin
      state_r <= state_nxt;

      // Mode register write
      if (cfg_wr && cfg_paddr == REG_MODE_ADDR) begin
        mode_r <= cfg_pwdata[0];
      end

      // Append a letter to the square
      if (app_en) begin
        used_r[cand] <= 1'b1;
        fill_r       <= fill_r + 5'd1;
      end

      // Start of a message byte: begin the alphabet walk if needed
      if (state_r == ST_IDLE && in_acc && in_tuser == CMD_MSG) begin
        k_r <= '0;
      end
      if (state_r == ST_FILL) begin
        k_r <= k_r + 5'd1;
        if (k_r == LETTER_LAST) complete_r <= 1'b1;
      end

      // Pair forming
      if (state_r == ST_PROC && proc_ok) begin
        if (!pend_v_r) begin
          pend_r   <= proc_idx;
          pend_v_r <= 1'b1;
        end else if (mode_r || pend_r != proc_idx) begin
          pend_v_r <= 1'b0;
        end
      end

      // End of message: clear the square and the pending letter
      if (state_r == ST_IDLE && in_acc && in_tuser == CMD_END) begin
        used_r     <= '0;
        fill_r     <= '0;
        complete_r <= 1'b0;
        pend_r     <= '0;
        pend_v_r   <= 1'b0;
      end

      // Output buffer count
      if (state_r == ST_LK_OUT && cnt_r == 2'd0) begin
        cnt_r <= 2'd2;
      end else if (out_acc) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      char_r <= in_tdata;
    end
    if (state_r == ST_IDLE && in_acc && in_tuser == CMD_END) begin
      pair_a_r <= pend_r;
      pair_b_r <= LETTER_X;
    end
    if (state_r == ST_PROC) begin
      pair_a_r <= pend_r;
      pair_b_r <= (!mode_r && pend_r == proc_idx) ? LETTER_X : proc_idx;
    end
    if (state_r == ST_LK_OUT && cnt_r == 2'd0) begin
      out_a_r <= sq_rd_a;
      out_b_r <= sq_rd_b;
    end
  end

  // Drive the result stream: first letter, then second with tlast
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tlast  = (cnt_r == 2'd1);
  assign out_tdata  = {1'b0, ASCII_A7 + {2'b00, (cnt_r == 2'd1) ? out_b_r : out_a_r}};

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CELLS)
    else $error("fill count beyond square size");

  a_second_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_tlast |=> out_tvalid && out_tlast)
    else $error("second letter of a pair missing");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == CMD_END |=> fill_r == 5'd0 && !complete_r && !pend_v_r)
    else $error("end command did not clear the square");

  a_fill_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FILL |-> !complete_r)
    else $error("alphabet walk on a completed square");

endmodule

/* sim/tb_playfair_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_playfair_cipher
// Self-checking bench for the streaming 5x5 Playfair block. A queue of key,
// message, end and unknown-command bytes feeds a clocked driver. A software
// copy of the square, the pending letter and the mode predicts the letters
// of every accepted byte. A clocked monitor checks each output transaction
// against the oldest prediction. Both sides idle in random bursts, and the
// receiver holds off once for a long stretch. The mode register changes
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_playfair_cipher;
  import pf_pkg::*;

  // Command value the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Idle cycles allowed after the last result before a register write
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 140;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
  } stream_byte_t;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } cipher_letter_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;    // [7:0] char_code
  logic [1:0]  in_tuser = 2'd0;    // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [6:0] letter, [7] zero
  logic        out_tlast;          // pair_last
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = 2'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  playfair_cipher u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stream_byte_t   pending_bytes[$];
  cipher_letter_t expected_letters[$];
  int error_count = 0;
  int items_queued = 0;
  int tx_gap_left = 0;
  int rx_stall_left = 0;
  int rx_hold_left = 0;
  bit quiet_run = 1'b0;

  // Square state mirrored in the bench
  logic [4:0]  sq_letter [NUM_CELLS];
  logic [4:0]  sq_cell [NUM_LETTERS];
  logic [25:0] sq_used;
  int          sq_count;
  bit          sq_complete;
  logic [4:0]  held_letter;
  bit          held_valid;
  bit          mode_decrypt;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Case fold, J into I; NO_LETTER for anything else
  function automatic logic [4:0] fold_letter(input logic [7:0] ch);
    logic [7:0] diff;
    logic [4:0] idx;
    idx = NO_LETTER;
    if (ch >= ASCII_UA && ch <= ASCII_UZ) begin
      diff = ch - ASCII_UA;
      idx = diff[4:0];
    end else if (ch >= ASCII_LA && ch <= ASCII_LZ) begin
      diff = ch - ASCII_LA;
      idx = diff[4:0];
    end
    if (idx == LETTER_J) idx = LETTER_I;
    return idx;
  endfunction

  function automatic void clear_square();
    sq_used = 26'd0;
    sq_count = 0;
    sq_complete = 1'b0;
    held_letter = 5'd0;
    held_valid = 1'b0;
  endfunction

  function automatic void place_letter(input logic [4:0] idx);
    if (idx > LETTER_LAST || idx == LETTER_J) return;
    if (sq_used[idx]) return;
    if (sq_count >= NUM_CELLS) return;
    sq_letter[sq_count] = idx;
    sq_cell[idx] = sq_count[4:0];
    sq_used[idx] = 1'b1;
    sq_count++;
  endfunction

  function automatic void finish_square();
    for (int k = 0; k < NUM_LETTERS; k++) place_letter(k[4:0]);
    sq_complete = 1'b1;
  endfunction

  // Apply the row, column or rectangle rule and store both letters
  function automatic void cipher_pair(input logic [4:0] a, input logic [4:0] b);
    int shift, pa, pb, ra, ca, rb, cb, oa, ob;
    cipher_letter_t res;
    shift = mode_decrypt ? 4 : 1;
    pa = sq_cell[a];
    pb = sq_cell[b];
    ra = pa / 5;
    ca = pa % 5;
    rb = pb / 5;
    cb = pb % 5;
    if (ra == rb) begin
      oa = ra * 5 + (ca + shift) % 5;
      ob = rb * 5 + (cb + shift) % 5;
    end else if (ca == cb) begin
      oa = ((ra + shift) % 5) * 5 + ca;
      ob = ((rb + shift) % 5) * 5 + cb;
    end else begin
      oa = ra * 5 + cb;
      ob = rb * 5 + ca;
    end
    res.letter = ASCII_A7 + {2'b00, sq_letter[oa]};
    res.last = 1'b0;
    expected_letters = {expected_letters, res};
    res.letter = ASCII_A7 + {2'b00, sq_letter[ob]};
    res.last = 1'b1;
    expected_letters = {expected_letters, res};
  endfunction

  // Advance the mirrored state by one accepted byte
  function automatic void cipher_step(input logic [1:0] cmd, input logic [7:0] ch);
    logic [4:0] idx;
    logic [7:0] diff;
    case (cmd)
      CMD_KEY: begin
        if (!sq_complete) place_letter(fold_letter(ch));
      end
      CMD_MSG: begin
        if (!sq_complete) finish_square();
        if (mode_decrypt) begin
          if (ch < ASCII_UA || ch > ASCII_UZ || ch == ASCII_UJ) return;
          diff = ch - ASCII_UA;
          idx = diff[4:0];
          if (!held_valid) begin
            held_letter = idx;
            held_valid = 1'b1;
          end else begin
            cipher_pair(held_letter, idx);
            held_valid = 1'b0;
          end
        end else begin
          idx = fold_letter(ch);
          if (idx == NO_LETTER) return;
          if (!held_valid) begin
            held_letter = idx;
            held_valid = 1'b1;
          end else if (held_letter == idx) begin
            // doubled letter: pad with X and keep the letter pending
            cipher_pair(held_letter, LETTER_X);
          end else begin
            cipher_pair(held_letter, idx);
            held_valid = 1'b0;
          end
        end
      end
      CMD_END: begin
        if (held_valid && !mode_decrypt && sq_complete) cipher_pair(held_letter, LETTER_X);
        clear_square();
      end
      default: ;
    endcase
  endfunction

  // Drive the input stream from the byte queue
  always @(posedge clk) begin : drive_input
    stream_byte_t sent;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        sent = pending_bytes.pop_front();
        cipher_step(sent.cmd, sent.ch);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_tvalid <= 1'b0;
        end else if (!quiet_run && pending_bytes.size() != 0 && $urandom_range(0, 7) == 0) begin
          tx_gap_left = $urandom_range(0, 3);
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_bytes[0].ch;
          in_tuser <= pending_bytes[0].cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each output transaction and throttle the receiver
  always @(posedge clk) begin : watch_output
    cipher_letter_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_letters.size() == 0) begin
          report_mismatch($sformatf("unexpected letter 0x%02h", out_tdata[6:0]));
        end else begin
          want = expected_letters.pop_front();
          if (out_tdata[6:0] !== want.letter)
            report_mismatch($sformatf("letter 0x%02h, want 0x%02h",
                                      out_tdata[6:0], want.letter));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("pair_last %b, want %b", out_tlast, want.last));
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
        rx_stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] ch);
    stream_byte_t item;
    item.cmd = cmd;
    item.ch = ch;
    pending_bytes = {pending_bytes, item};
    items_queued++;
  endtask

  task automatic queue_text(input logic [1:0] cmd, input string s);
    for (int k = 0; k < s.len(); k++) queue_item(cmd, s[k]);
  endtask

  function automatic logic [7:0] random_letter(input bit upper_only);
    logic [7:0] base;
    base = (upper_only || $urandom_range(0, 1)) ? ASCII_UA : ASCII_LA;
    return base + 8'($urandom_range(0, 25));
  endfunction

  // Key, then message with occasional noise and doubles, then usually an end
  task automatic queue_random_message(input bit decrypt);
    int key_len, msg_len;
    logic [7:0] ch, prev;
    key_len = $urandom_range(0, 12);
    for (int k = 0; k < key_len; k++)
      queue_item(CMD_KEY, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : random_letter(1'b0));
    msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 24);
    prev = ASCII_UA;
    for (int k = 0; k < msg_len; k++) begin
      case ($urandom_range(0, 19))
        0: ch = 8'($urandom_range(0, 255));
        1: begin
          queue_item(CMD_KEY, 8'($urandom_range(0, 255)));
          ch = random_letter(decrypt);
        end
        2, 3: ch = prev;
        default: ch = random_letter(decrypt);
      endcase
      queue_item(CMD_MSG, ch);
      prev = ch;
    end
    if ($urandom_range(0, 19) == 0) queue_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) != 0) queue_item(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  // Wait until every byte is taken and every letter seen, then let it settle
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_tvalid || expected_letters.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input bit decrypt);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_MODE_ADDR;
    cfg_pwdata <= {31'd0, decrypt};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    mode_decrypt = decrypt;
  endtask

  initial begin : run_phases
    bit decrypt;
    int target;
    clear_square();
    mode_decrypt = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Encrypt: key with J, case and non-letters; row, column, rectangle,
    // doubled letter, doubled X, dropped bytes, late key byte, final pad
    write_mode(1'b0);
    queue_item(CMD_UNUSED, 8'hFF);
    queue_text(CMD_KEY, "Jk");
    queue_item(CMD_KEY, 8'h00);
    queue_item(CMD_KEY, 8'hFF);
    queue_text(CMD_MSG, "bCiVeoLL@jXX");
    queue_item(CMD_MSG, 8'hFF);
    queue_text(CMD_KEY, "Q");
    queue_item(CMD_END, 8'h00);
    wait_drained();

    // Decrypt: lowercase, J and symbols dropped, lone final letter dropped
    write_mode(1'b1);
    queue_text(CMD_KEY, "z");
    queue_text(CMD_MSG, "aJ[AZM");
    queue_item(CMD_END, 8'hFF);
    wait_drained();

    // Random phases; a message left open carries across a mode change
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      decrypt = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      write_mode(decrypt);
      if (phase == 2) rx_hold_left = HOLD_OFF_CYCLES;
      if (phase == NUM_PHASES - 1) quiet_run = 1'b1;
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) queue_random_message(decrypt);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
